// File: rtl/core/tiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiq_pkg
// Shared types and constants of the trie insert/query core: command and
// status codes, controller states and the row edit controls.
// ----------------------------------------------------------------------------
package tiq_pkg;

    // Fixed field widths of the command interface.
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 5;
    localparam int STATUS_W = 2;

    // Commands carried by an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_ALLOC,
        S_FIN
    } t_state;

    // Edits applied to a node row on its way back to memory.
    typedef struct packed {
        logic set_child;
        logic set_count;
    } t_row_edit;

endpackage : tiq_pkg
`default_nettype wire

// File: rtl/core/tiq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiq_ram
// Generic simple dual-port RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module tiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : tiq_ram
`default_nettype wire

// File: rtl/core/tiq_row_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiq_row_unit
// Node row datapath: picks the child pointer for a symbol, increments the
// end count with saturation, and builds the modified row for write-back.
// ----------------------------------------------------------------------------
module tiq_row_unit
    import tiq_pkg::*;
#(
    parameter int NODE_W     = 12,
    parameter int ALPHABET   = 26,
    parameter int COUNT_BITS = 16
) (
    input  wire logic [COUNT_BITS+ALPHABET*NODE_W-1:0] i_row,
    input  wire logic [SYM_W-1:0]                      i_symbol,
    input  wire logic [NODE_W-1:0]                     i_new_child,
    input  wire t_row_edit                             i_edit,
    output logic      [NODE_W-1:0]                     o_child,
    output logic      [COUNT_BITS-1:0]                 o_count,
    output logic      [COUNT_BITS-1:0]                 o_count_inc,
    output logic      [COUNT_BITS+ALPHABET*NODE_W-1:0] o_row
);

    localparam int SLOT_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    logic [NODE_W-1:0] slots [ALPHABET];
    logic [SLOT_W-1:0] sym_idx;

    // The symbol is range checked by the controller before its child is used.
    assign sym_idx = SLOT_W'(i_symbol);

    // Unpack the child pointers and rebuild them with the optional new child.
    for (genvar i = 0; i < ALPHABET; i++) begin : g_slot
        assign slots[i] = i_row[COUNT_BITS + i*NODE_W +: NODE_W];
        assign o_row[COUNT_BITS + i*NODE_W +: NODE_W] =
            (i_edit.set_child && (sym_idx == SLOT_W'(i))) ? i_new_child : slots[i];
    end

    assign o_child = slots[sym_idx];

    // End count with saturating increment.
    assign o_count     = i_row[COUNT_BITS-1:0];
    assign o_count_inc = (o_count == {COUNT_BITS{1'b1}}) ? o_count
                                                         : o_count + COUNT_BITS'(1);
    assign o_row[COUNT_BITS-1:0] = i_edit.set_count ? o_count_inc : o_count;

endmodule : tiq_row_unit
`default_nettype wire

// File: rtl/core/trie_insert_query_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_insert_query_core
// Array-based trie fed one symbol per transaction. Each node owns one memory
// row holding its end count and one child pointer per letter.
// ----------------------------------------------------------------------------
// Sequence: an accepted symbol passes through S_EXEC, then S_ALLOC when it
//   allocates a node or S_FIN when it ends a string on an existing node; the
//   result strobe is raised in the cycle after the last busy state.
// Overlap: a new symbol is accepted only once the controller is back in S_IDLE,
//   set by the row memory's registered read port and its single write port.
// Reset and clear: S_INIT zeroes the root row, busy meanwhile; S_ALLOC zeroes
//   each new row, count one if its string ends. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module trie_insert_query_core
    import tiq_pkg::*;
#(
    parameter int NODES      = 4096,
    parameter int ALPHABET   = 26,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [SYM_W-1:0]      i_symbol,
    input  wire logic                  i_last,
    output logic                       o_valid,
    output logic      [COUNT_BITS-1:0] o_count,
    output logic      [STATUS_W-1:0]   o_status
);

    localparam int NODE_W = $clog2(NODES);
    localparam int ROW_W  = COUNT_BITS + ALPHABET * NODE_W;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    // Control registers.
    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [NODE_W-1:0]   r_next_free, n_next_free;
    logic                r_missed, n_missed;
    logic                r_overflowed, n_overflowed;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    t_cmd                r_cmd, n_cmd;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic                r_last, n_last;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    t_status             r_out_status, n_out_status;

    // Memory and row datapath signals.
    logic                ram_wr_en, ram_rd_en;
    logic [NODE_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [ROW_W-1:0]    ram_wr_data, ram_rd_data;
    t_row_edit           row_edit;
    logic [NODE_W-1:0]   row_child;
    logic [COUNT_BITS-1:0] row_count, row_count_inc;
    logic [ROW_W-1:0]    row_mod;
    logic [NODE_W-1:0]   new_node;

    // Step decisions.
    logic accept, step_live, sym_ok, is_ins, child_none;
    logic need_alloc, hit_full, hit_miss, moved;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign new_node  = r_next_free + NODE_W'(1);

    // Decisions taken on the row read for the current symbol.
    assign step_live  = !r_missed && !r_overflowed;
    assign sym_ok     = (32'(r_sym) < ALPHABET);
    assign is_ins     = (r_cmd == CMD_INSERT);
    assign child_none = (row_child == '0);
    assign need_alloc = step_live && sym_ok && is_ins && child_none
                        && (r_next_free != LAST_NODE);
    assign hit_full   = step_live && sym_ok && is_ins && child_none
                        && (r_next_free == LAST_NODE);
    assign hit_miss   = step_live && (!sym_ok || (!is_ins && child_none));
    assign moved      = step_live && sym_ok && !child_none;

    // Node row memory.
    tiq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Row decode and modify.
    tiq_row_unit #(
        .NODE_W     (NODE_W),
        .ALPHABET   (ALPHABET),
        .COUNT_BITS (COUNT_BITS)
    ) u_row_unit (
        .i_row       (ram_rd_data),
        .i_symbol    (r_sym),
        .i_new_child (new_node),
        .i_edit      (row_edit),
        .o_child     (row_child),
        .o_count     (row_count),
        .o_count_inc (row_count_inc),
        .o_row       (row_mod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR:             n_state = S_INIT;
                        CMD_INSERT, CMD_QUERY: n_state = S_EXEC;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (need_alloc) begin
                    n_state = S_ALLOC;
                end else if (r_last && moved) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ALLOC: begin
                n_state = S_IDLE;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and results. Every write completes before the
    // controller returns to idle, so a later read never overlaps a pending
    // write to the same row.
    always_comb begin
        n_cur        = r_cur;
        n_next_free  = r_next_free;
        n_missed     = r_missed;
        n_overflowed = r_overflowed;
        n_cmd        = r_cmd;
        n_sym        = r_sym;
        n_last       = r_last;
        n_out_valid  = 1'b0;
        n_out_count  = '0;
        n_out_status = ST_OK;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_cur;
        ram_wr_data  = row_mod;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_cur;
        row_edit     = '0;
        case (r_state)
            S_INIT: begin
                // Zero the root row.
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = '0;
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = t_cmd'(i_cmd);
                    n_sym  = i_symbol;
                    n_last = i_last;
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR: begin
                            n_cur        = '0;
                            n_next_free  = '0;
                            n_missed     = 1'b0;
                            n_overflowed = 1'b0;
                        end
                        CMD_INSERT, CMD_QUERY: begin
                            ram_rd_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (need_alloc) begin
                    // Link the new child into the parent row.
                    row_edit.set_child = 1'b1;
                    ram_wr_en          = 1'b1;
                    n_next_free        = new_node;
                    n_cur              = new_node;
                end else if (hit_full) begin
                    n_overflowed = 1'b1;
                end else if (hit_miss) begin
                    n_missed = 1'b1;
                end else if (moved) begin
                    n_cur = row_child;
                    if (r_last) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = row_child;
                    end
                end
                // A string that failed ends here with no count.
                if (r_last && !need_alloc && !moved) begin
                    n_out_valid  = 1'b1;
                    n_out_status = (r_overflowed || hit_full) ? ST_FULL : ST_NOT_FOUND;
                    n_cur        = '0;
                    n_missed     = 1'b0;
                    n_overflowed = 1'b0;
                end
            end
            S_ALLOC: begin
                // Fresh row; an insert ending here counts its first occurrence.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_next_free;
                ram_wr_data = ROW_W'(r_last);
                if (r_last) begin
                    n_out_valid = 1'b1;
                    n_out_count = COUNT_BITS'(1);
                    n_cur       = '0;
                end
            end
            S_FIN: begin
                // End node row is on the read port.
                n_out_valid = 1'b1;
                n_cur       = '0;
                if (is_ins) begin
                    row_edit.set_count = 1'b1;
                    ram_wr_en          = 1'b1;
                    n_out_count        = row_count_inc;
                end else begin
                    n_out_count = row_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cur        <= '0;
            r_next_free  <= '0;
            r_missed     <= 1'b0;
            r_overflowed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_next_free  <= n_next_free;
            r_missed     <= n_missed;
            r_overflowed <= n_overflowed;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_count  = r_out_count;
    assign o_status = r_out_status;

    // No two results fall in consecutive cycles.
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result transactions in consecutive cycles");

    // A failed string never reports a count.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_count == '0))
        else $error("nonzero count with failing status");

    // The walk pointer always stays inside the allocated pool.
    a_cur_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_next_free)
        else $error("current node beyond the allocated pool");

    // No row write overlaps the read issued at acceptance.
    a_no_wr_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !ram_wr_en)
        else $error("row write coincides with an accepted transaction");

    // The pool counter moves only by allocation or clear.
    a_free_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != $past(r_next_free)) |->
            ((r_next_free == '0) || (r_state == S_ALLOC)))
        else $error("node pool counter changed without allocation or clear");

endmodule : trie_insert_query_core
`default_nettype wire
